// ===== design/wrs_pkg.sv =====
// Package for the windowed running statistics block.
// Holds field widths, item kind codes and the controller/datapath command types.
// No dependencies.
package wrs_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int FILLED_W   = 8;
	localparam int WINDOW_DEF = 128;

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;   // latch the input word
		logic mem_rd;    // read the ring slot at the write index
		logic update;    // apply add or clear to the statistics
		logic div_load;  // start the serial divider
		logic div_step;  // one divider iteration
		logic load_out;  // move the result into the output register
	} wrs_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic div_last;  // current divider step is the final one
	} wrs_status_t;

endpackage

// ===== design/wrs_if.sv =====
// Channel interfaces for the windowed running statistics block.
// Depends on wrs_pkg for field widths.
interface wrs_in_if import wrs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, kind, sample, input ready);
	modport sink   (input valid, kind, sample, output ready);
endinterface

interface wrs_out_if import wrs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] average;
	logic [SAMPLE_W-1:0] minimum;
	logic [SAMPLE_W-1:0] maximum;
	logic [SAMPLE_W-1:0] newest;
	logic [FILLED_W-1:0] filled;

	modport source (output valid, average, minimum, maximum, newest, filled, input ready);
	modport sink   (input valid, average, minimum, maximum, newest, filled, output ready);
endinterface

// ===== design/wrs_ctrl.sv =====
// Controller state machine for the windowed running statistics block.
// Depends on wrs_pkg for the command and status structs.
module wrs_ctrl import wrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  wrs_status_t status,
	output wrs_cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_READ   = 6'b000010,
		ST_UPDATE = 6'b000100,
		ST_DIVLD  = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_DIVLD;
			end
			ST_DIVLD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/wrs_datapath.sv =====
// Datapath for the windowed running statistics block: sample ring, window sum,
// fill count, running min/max, serial restoring divider and output register.
// Depends on wrs_pkg.
module wrs_datapath import wrs_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wrs_cmd_t            cmd,
	output wrs_status_t         status,
	input  logic                in_kind,
	input  logic [SAMPLE_W-1:0] in_sample,
	output logic [SAMPLE_W-1:0] average,
	output logic [SAMPLE_W-1:0] minimum,
	output logic [SAMPLE_W-1:0] maximum,
	output logic [SAMPLE_W-1:0] newest,
	output logic [FILLED_W-1:0] filled
);

	localparam int IDX_W     = $clog2(WINDOW);
	localparam int CNT_W     = $clog2(WINDOW + 1);
	localparam int SUM_W     = SAMPLE_W + IDX_W;
	localparam int DIV_CNT_W = $clog2(SUM_W);

	logic [SAMPLE_W-1:0]  ring [WINDOW];
	logic [SAMPLE_W-1:0]  rd_data_q;
	logic                 kind_q;
	logic [SAMPLE_W-1:0]  sample_q;
	logic [IDX_W-1:0]     wr_idx_q;
	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SAMPLE_W-1:0]  min_q;
	logic [SAMPLE_W-1:0]  max_q;
	logic [SAMPLE_W-1:0]  newest_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic                 full;
	logic [SUM_W-1:0]     sum_sub;
	logic [CNT_W:0]       rem_shift;
	logic [CNT_W:0]       rem_trial;
	logic                 q_bit;
	logic                 empty;

	assign full     = (count_q == CNT_W'(WINDOW));
	assign sum_sub  = full ? SUM_W'(rd_data_q) : '0;
	assign empty    = (count_q == '0);

	assign rem_shift = {rem_q, quo_q[SUM_W-1]};
	assign rem_trial = rem_shift - {1'b0, count_q};
	assign q_bit     = (rem_shift >= {1'b0, count_q});

	assign status.div_last = (div_cnt_q == '0);

	// ring memory: no reset; the slot read is only used once the window is full, so stale entries never count
	always_ff @(posedge clk) begin
		if (cmd.update && kind_q == KIND_ADD) begin
			ring[wr_idx_q] <= sample_q;
		end
		if (cmd.mem_rd) begin
			rd_data_q <= ring[wr_idx_q];
		end
	end

	// input word, divider payload, newest sample and output register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= in_kind;
			sample_q <= in_sample;
		end
		if (cmd.div_load) begin
			quo_q     <= sum_q;
			rem_q     <= '0;
			div_cnt_q <= DIV_CNT_W'(SUM_W - 1);
		end else if (cmd.div_step) begin
			quo_q     <= {quo_q[SUM_W-2:0], q_bit};
			rem_q     <= q_bit ? rem_trial[CNT_W-1:0] : rem_shift[CNT_W-1:0];
			div_cnt_q <= div_cnt_q - 1'b1;
		end
		if (cmd.update && kind_q == KIND_ADD) begin
			newest_q <= sample_q;
		end
		if (cmd.load_out) begin
			average <= empty ? '0 : quo_q[SAMPLE_W-1:0];
			minimum <= empty ? '0 : min_q;
			maximum <= empty ? '0 : max_q;
			newest  <= empty ? '0 : newest_q;
			filled  <= FILLED_W'(count_q);
		end
	end

	// statistics state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			count_q  <= '0;
			sum_q    <= '0;
			min_q    <= '1;
			max_q    <= '0;
		end else if (cmd.update) begin
			if (kind_q == KIND_CLEAR) begin
				wr_idx_q <= '0;
				count_q  <= '0;
				sum_q    <= '0;
				min_q    <= '1;
				max_q    <= '0;
			end else begin
				// drop the oldest sample once the window is full
				sum_q <= sum_q - sum_sub + SUM_W'(sample_q);
				if (sample_q < min_q) begin
					min_q <= sample_q;
				end
				if (sample_q > max_q) begin
					max_q <= sample_q;
				end
				if (wr_idx_q == IDX_W'(WINDOW - 1)) begin
					wr_idx_q <= '0;
				end else begin
					wr_idx_q <= wr_idx_q + 1'b1;
				end
				if (!full) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/windowed_running_stats.sv =====
// Windowed running statistics: window average, min/max since the last clear, newest sample, fill count.
// Each word goes through capture, ring read, update, divider load, the serial divide and finish;
// a new word is taken only once the previous one has left finish. SUM_W = 24 + clog2(WINDOW) is
// the width of the sum fed to the one-bit-per-cycle restoring divider that forms sum / count.
// Reset clears count, sum, write index and max, sets min to all ones; the ring is not cleared.
// Depends on wrs_pkg, wrs_if, wrs_ctrl and wrs_datapath.
module windowed_running_stats import wrs_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	wrs_in_if.sink   item,
	wrs_out_if.source result
);

	wrs_cmd_t    cmd;
	wrs_status_t status;

	// Controller: one word in flight at a time. A new word is taken while the
	// previous result still waits in the output register.
	wrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: ring memory read of the oldest slot, then sum/min/max update,
	// then the serial divide; the output register masks all fields to zero
	// while the window is empty.
	wrs_datapath #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_kind   (item.kind),
		.in_sample (item.sample),
		.average   (result.average),
		.minimum   (result.minimum),
		.maximum   (result.maximum),
		.newest    (result.newest),
		.filled    (result.filled)
	);

	// a word is processed alone: no accept in the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("input accepted while a word is in flight");

	// window average lies between the min and max since the last clear
	a_avg_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.filled != '0) |->
		(result.minimum <= result.average && result.average <= result.maximum))
		else $error("average outside min/max");

	// newest sample lies between min and max
	a_newest_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.filled != '0) |->
		(result.minimum <= result.newest && result.newest <= result.maximum))
		else $error("newest outside min/max");

	// an empty window reports all zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(WINDOW < 256 && result.valid && result.filled == '0) |->
		(result.average == '0 && result.minimum == '0 &&
		 result.maximum == '0 && result.newest == '0))
		else $error("empty window reports nonzero statistics");

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for windowed_running_stats: random bursty sample and clear words
// against an in-bench predictor of window average, min/max since the last clear, newest and fill count.
// Depends on wrs_pkg, wrs_if and the windowed_running_stats RTL.
module testbench;
	import wrs_pkg::*;

	localparam int WINDOW       = WINDOW_DEF;
	localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW);
	// input accept to result valid while the output register is free
	localparam int LATENCY      = 3 + SUM_W + 1;
	localparam int RANDOM_WORDS = 1200;
	localparam int MAX_GAP      = 45;
	localparam int MAX_STALL    = 60;
	// long receiver hold-off, started once enough words went in
	localparam int HOLD_AT      = 400;
	localparam int HOLD_OFF     = 1200;
	localparam int WATCHDOG     = 4 * (HOLD_OFF + MAX_GAP + MAX_STALL + 2 * LATENCY);

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

	typedef struct {
		logic                kind;
		logic [SAMPLE_W-1:0] sample;
		bit                  wait_drain;  // hold this word until every result is back
	} sample_word_t;

	typedef struct {
		logic [SAMPLE_W-1:0] average;
		logic [SAMPLE_W-1:0] minimum;
		logic [SAMPLE_W-1:0] maximum;
		logic [SAMPLE_W-1:0] newest;
		logic [FILLED_W-1:0] filled;
	} window_stats_t;

	logic clk;
	logic arst_n;

	wrs_in_if  item_ch();
	wrs_out_if result_ch();

	windowed_running_stats #(.WINDOW(WINDOW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch.sink),
		.result (result_ch.source)
	);

	// words still to be offered, and statistics still owed by the block
	sample_word_t  feed[$];
	window_stats_t expected_stats[$];

	int total_words     = 0;
	int words_taken     = 0;
	int results_owed    = 0;
	int results_checked = 0;
	int clears_seen     = 0;
	int full_windows    = 0;
	int mismatches      = 0;
	int idle_cycles     = 0;

	// predictor copy of the block state
	logic [SAMPLE_W-1:0] ring_copy [WINDOW];
	int                  slot_next  = 0;
	int                  fill_count = 0;
	logic [SUM_W-1:0]    win_sum    = '0;
	logic [SAMPLE_W-1:0] low_mark   = SAMPLE_MAX;
	logic [SAMPLE_W-1:0] high_mark  = '0;

	// Apply one accepted word to the predictor state and return the statistics it reports.
	function automatic window_stats_t advance_stats(input logic kind,
			input logic [SAMPLE_W-1:0] sample);
		window_stats_t r;
		int            prev_slot;
		if (kind == KIND_CLEAR) begin
			// ring entries stay stale; none is read before it is written again
			slot_next  = 0;
			fill_count = 0;
			win_sum    = '0;
			low_mark   = SAMPLE_MAX;
			high_mark  = '0;
			clears_seen++;
		end else begin
			// full window: retire the oldest sample before overwriting its slot
			if (fill_count >= WINDOW)
				win_sum = win_sum - SUM_W'(ring_copy[slot_next]);
			ring_copy[slot_next] = sample;
			win_sum = win_sum + SUM_W'(sample);
			if (sample < low_mark)
				low_mark = sample;
			if (sample > high_mark)
				high_mark = sample;
			slot_next = (slot_next + 1) % WINDOW;
			if (fill_count < WINDOW)
				fill_count++;
		end
		r = '{default: '0};
		r.filled = FILLED_W'(fill_count);
		// empty window reports all zeros
		if (fill_count != 0) begin
			prev_slot = (slot_next + WINDOW - 1) % WINDOW;
			r.average = SAMPLE_W'(win_sum / SUM_W'(fill_count));
			r.minimum = low_mark;
			r.maximum = high_mark;
			r.newest  = ring_copy[prev_slot];
		end
		if (fill_count == WINDOW)
			full_windows++;
		return r;
	endfunction

	function automatic void queue_word(input logic kind, input logic [SAMPLE_W-1:0] sample,
			input bit wait_drain);
		sample_word_t w;
		w.kind       = kind;
		w.sample     = sample;
		w.wait_drain = wait_drain;
		feed.insert(feed.size(), w);
		total_words++;
	endfunction

	task automatic check_field(input string field, input logic [SAMPLE_W-1:0] want,
			input logic [SAMPLE_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: offer words from the feed in bursts of random length with random gaps.
	int  gap_left   = 0;
	int  burst_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid  <= 1'b0;
			item_ch.kind   <= KIND_ADD;
			item_ch.sample <= '0;
			gap_left       <= 0;
			burst_left     <= 0;
		end else if (!item_ch.valid || item_ch.ready) begin
			// current word (if any) is gone: pick what to show next
			if (gap_left != 0) begin
				gap_left      <= gap_left - 1;
				item_ch.valid <= 1'b0;
			end else if (feed.size() == 0 ||
					(feed[0].wait_drain && (item_ch.valid || results_owed != 0))) begin
				// nothing left, or a drain point: hold off until the block is empty
				item_ch.valid <= 1'b0;
			end else begin
				item_ch.valid  <= 1'b1;
				item_ch.kind   <= feed[0].kind;
				item_ch.sample <= feed[0].sample;
				void'(feed.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: alternate ready runs and stalls of random length; once, hold off long
	// enough that the block backs up and stalls its input.
	int hold_left  = 0;
	int stall_left = 0;
	int run_left   = 0;
	bit hold_done  = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left       <= 0;
			stall_left      <= 0;
			run_left        <= 0;
			hold_done       <= 1'b0;
		end else if (!hold_done && words_taken >= HOLD_AT) begin
			hold_done       <= 1'b1;
			hold_left       <= HOLD_OFF;
			result_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left       <= hold_left - 1;
			result_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left      <= stall_left - 1;
			result_ch.ready <= 1'b0;
		end else if (run_left != 0) begin
			run_left        <= run_left - 1;
			result_ch.ready <= 1'b1;
		end else begin
			// new stretch: a ready run, with a stall before it three times in four
			run_left        <= $urandom_range(1, 200);
			stall_left      <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_STALL);
			result_ch.ready <= 1'b1;
		end
	end

	// Monitor: predict on every accepted input word, check every accepted result.
	always @(posedge clk) begin
		window_stats_t want;
		window_stats_t pred;
		bit            moved;
		if (arst_n) begin
			moved = 1'b0;
			if (item_ch.valid && item_ch.ready) begin
				pred = advance_stats(item_ch.kind, item_ch.sample);
				expected_stats.insert(expected_stats.size(), pred);
				words_taken <= words_taken + 1;
				moved = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				moved = 1'b1;
				if (expected_stats.size() == 0) begin
					$display("%0t: result with none expected, actual avg %h min %h max %h new %h n %h",
						$time, result_ch.average, result_ch.minimum, result_ch.maximum,
						result_ch.newest, result_ch.filled);
					mismatches++;
				end else begin
					want = expected_stats.pop_front();
					check_field("average", want.average, result_ch.average);
					check_field("minimum", want.minimum, result_ch.minimum);
					check_field("maximum", want.maximum, result_ch.maximum);
					check_field("newest",  want.newest,  result_ch.newest);
					check_field("filled",  SAMPLE_W'(want.filled), SAMPLE_W'(result_ch.filled));
				end
				results_checked <= results_checked + 1;
			end
			results_owed <= expected_stats.size();
			idle_cycles  <= moved ? 0 : idle_cycles + 1;
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	initial begin
		while (idle_cycles < WATCHDOG)
			@(negedge clk);
		$display("watchdog: no word accepted for %0d cycles", WATCHDOG);
		$display("TB_ERROR");
		$finish;
	end

	// Stimulus and end of run.
	initial begin : stimulus
		int                  seg_left;
		int                  flavor;
		logic                kind;
		logic [SAMPLE_W-1:0] s;

		arst_n = 1'b0;

		// directed: empty window, field extremes, clears back to back, ignored clear sample
		queue_word(KIND_CLEAR, '0,             1'b0);
		queue_word(KIND_ADD,   '0,             1'b0);
		queue_word(KIND_ADD,   SAMPLE_MAX,     1'b0);
		queue_word(KIND_ADD,   24'h000001,     1'b0);
		queue_word(KIND_ADD,   SAMPLE_MAX - 1, 1'b0);
		queue_word(KIND_ADD,   24'h800000,     1'b0);
		queue_word(KIND_ADD,   24'h555555,     1'b0);
		queue_word(KIND_ADD,   24'hAAAAAA,     1'b0);
		queue_word(KIND_CLEAR, SAMPLE_MAX,     1'b0);
		queue_word(KIND_CLEAR, 24'h5A5A5A,     1'b0);
		queue_word(KIND_ADD,   SAMPLE_MAX,     1'b0);
		queue_word(KIND_ADD,   SAMPLE_MAX,     1'b0);
		queue_word(KIND_ADD,   24'h000000,     1'b0);
		queue_word(KIND_CLEAR, '0,             1'b0);
		queue_word(KIND_ADD,   24'h123456,     1'b0);
		queue_word(KIND_ADD,   24'h000003,     1'b0);

		// random: segments of one sample flavor, mostly long enough to wrap the window,
		// each opened by a clear half the time, with rare clears as noise inside
		seg_left = 0;
		flavor   = 0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(10, 400);
				flavor   = $urandom_range(0, 3);
				kind     = ($urandom_range(0, 1) != 0) ? KIND_CLEAR : KIND_ADD;
			end else begin
				seg_left--;
				kind = ($urandom_range(0, 99) == 0) ? KIND_CLEAR : KIND_ADD;
			end
			case (flavor)
				0: s = SAMPLE_W'($urandom);
				1: s = SAMPLE_MAX;                       // drive the window sum to its top
				2: s = SAMPLE_W'($urandom_range(0, 15));
				default: begin
					case ($urandom_range(0, 3))
						0: s = '0;
						1: s = SAMPLE_MAX;
						2: s = 24'h000001;
						default: s = SAMPLE_MAX - 1;
					endcase
				end
			endcase
			// drain before the random part and once halfway through it
			queue_word(kind, s, n == 0 || n == RANDOM_WORDS / 2);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_taken < total_words)
			@(negedge clk);
		while (expected_stats.size() != 0)
			@(negedge clk);
		repeat (4 * LATENCY) @(negedge clk);

		if (expected_stats.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_stats.size());
			mismatches++;
		end
		$display("sent %0d words (%0d clears), checked %0d results, %0d with a full window",
			words_taken, clears_seen, results_checked, full_windows);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
design/wrs_pkg.sv
design/wrs_if.sv
design/wrs_ctrl.sv
design/wrs_datapath.sv
design/windowed_running_stats.sv
test/testbench.sv
